[rtl/tsbp_pkg.sv]
// Package for the tar stream block parser: constants, types and helpers.
// No dependencies.
`default_nettype none
package tsbp_pkg;

    localparam int SIZE_DIGITS = 12;
    localparam int SIZE_W = 36;
    localparam int OFF_W = 9;
    localparam logic [OFF_W-1:0] SIZE_OFF = 9'd124;
    localparam logic [OFF_W-1:0] SIZE_END = 9'(124 + SIZE_DIGITS);
    localparam logic [OFF_W-1:0] SUM_OFF = 9'd148;
    localparam logic [OFF_W-1:0] SUM_LAST = 9'd155;
    localparam logic [OFF_W-1:0] TYPE_OFF = 9'd156;
    localparam logic [OFF_W-1:0] LAST_OFF = 9'd511;
    localparam logic [7:0] SUM_FILL = 8'h20;
    localparam logic [7:0] TYPE_DIR = 8'h35;
    localparam logic [SIZE_W-1:0] MAX36 = {SIZE_W{1'b1}};

    typedef enum logic [2:0]
    {
        ST_IN_BLOCK = 3'd0,
        ST_HDR_OK = 3'd1,
        ST_DATA_DONE = 3'd2,
        ST_END = 3'd3,
        ST_CSUM_ERR = 3'd4,
        ST_HALTED = 3'd5
    } status_t;

    // Octal parse stage
    typedef enum logic [1:0]
    {
        PS_SKIP = 2'd0,
        PS_DIGITS = 2'd1,
        PS_DONE = 2'd2
    } pstage_t;

    typedef enum logic [2:0]
    {
        PH_HEADER = 3'b001,
        PH_DATA = 3'b010,
        PH_HALT = 3'b100
    } phase_t;

    // Classified byte handed from front to back
    typedef struct packed
    {
        logic [7:0] data;
        status_t status;
        logic [7:0] etype;
        logic [SIZE_W-1:0] size;
        logic hdr_ok;
        logic [OFF_W-1:0] off;
        logic in_data;
    } cls_t;

    typedef struct packed
    {
        logic [7:0] data_byte;
        logic payload_valid;
        logic [2:0] status;
        logic [7:0] entry_type;
        logic [SIZE_W-1:0] file_size;
        logic file_end;
    } res_t;

    typedef struct packed
    {
        logic [7:0] stream_byte;
    } in_t;

endpackage
`default_nettype wire

[rtl/tsbp_if.sv]
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
`default_nettype none
interface tsbp_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/tsbp_front.sv]
// Front: header parsing, checksum and octal fields, phase tracking per byte.
// Depends on tsbp_pkg.
`default_nettype none
module tsbp_front
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic [7:0] in_byte,
    output logic q_valid,
    input wire logic q_ready,
    output tsbp_pkg::cls_t q_data
);
    import tsbp_pkg::*;

    phase_t phase_reg, phase_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [16:0] bsum_reg, bsum_next;
    logic zero_reg, zero_next;
    logic [SIZE_W-1:0] sacc_reg, sacc_next;
    pstage_t sst_reg, sst_next;
    logic [23:0] cacc_reg, cacc_next;
    pstage_t cst_reg, cst_next;
    logic [7:0] type_reg, type_next;
    logic [SIZE_W-1:0] left_reg, left_next;
    logic fire;
    logic oct;
    logic [2:0] dig;
    logic [SIZE_W-1:0] size_eff;
    cls_t c;

    assign in_ready = q_ready;
    assign q_valid = in_valid;
    assign fire = in_valid && q_ready;
    assign oct = (in_byte >= 8'h30) && (in_byte <= 8'h37);
    assign dig = in_byte[2:0];
    assign size_eff = (type_reg == TYPE_DIR) ? '0 : sacc_reg;

    // Classify the byte and compute next header state
    always_comb
    begin
        phase_next = phase_reg;
        off_next = (off_reg == LAST_OFF) ? '0 : off_reg + 1'b1;
        bsum_next = bsum_reg;
        zero_next = zero_reg;
        sacc_next = sacc_reg;
        sst_next = sst_reg;
        cacc_next = cacc_reg;
        cst_next = cst_reg;
        type_next = type_reg;
        left_next = left_reg;
        c = '0;
        c.data = in_byte;
        c.off = off_reg;
        c.status = ST_IN_BLOCK;
        case (phase_reg)
            PH_HALT:
            begin
                off_next = off_reg;
                c.status = ST_HALTED;
            end
            PH_HEADER:
            begin
                if (off_reg >= SUM_OFF && off_reg <= SUM_LAST)
                    bsum_next = bsum_reg + 17'(SUM_FILL);
                else
                    bsum_next = bsum_reg + 17'(in_byte);
                if (in_byte != 8'd0)
                    zero_next = 1'b0;
                if (off_reg >= SIZE_OFF && off_reg < SIZE_END)
                begin
                    case (sst_reg)
                        PS_SKIP:
                            if (oct)
                            begin
                                sacc_next = SIZE_W'(dig);
                                sst_next = PS_DIGITS;
                            end
                        PS_DIGITS:
                            if (!oct)
                                sst_next = PS_DONE;
                            else if (sacc_reg[SIZE_W-1:SIZE_W-3] != 3'd0)
                                sacc_next = MAX36;
                            else
                                sacc_next = {sacc_reg[SIZE_W-4:0], dig};
                        default: ;
                    endcase
                end
                if (off_reg >= SUM_OFF && off_reg <= SUM_LAST)
                begin
                    case (cst_reg)
                        PS_SKIP:
                            if (oct)
                            begin
                                cacc_next = 24'(dig);
                                cst_next = PS_DIGITS;
                            end
                        PS_DIGITS:
                            if (!oct)
                                cst_next = PS_DONE;
                            else if (cacc_reg[23:21] != 3'd0)
                                cacc_next = 24'hFFFFFF;
                            else
                                cacc_next = {cacc_reg[20:0], dig};
                        default: ;
                    endcase
                end
                if (off_reg == TYPE_OFF)
                    type_next = in_byte;
                if (off_reg == LAST_OFF)
                begin
                    if (zero_next)
                    begin
                        c.status = ST_END;
                        phase_next = PH_HALT;
                    end
                    else if (24'(bsum_next) != cacc_reg)
                    begin
                        c.status = ST_CSUM_ERR;
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        c.status = ST_HDR_OK;
                        c.hdr_ok = 1'b1;
                        c.etype = type_reg;
                        c.size = size_eff;
                        left_next = size_eff;
                        phase_next = (size_eff != '0) ? PH_DATA : PH_HEADER;
                    end
                    bsum_next = '0;
                    zero_next = 1'b1;
                    sacc_next = '0;
                    sst_next = PS_SKIP;
                    cacc_next = '0;
                    cst_next = PS_SKIP;
                    type_next = '0;
                end
            end
            PH_DATA:
            begin
                c.in_data = 1'b1;
                if (left_reg != '0)
                    left_next = left_reg - 1'b1;
                if (off_reg == LAST_OFF)
                begin
                    c.status = ST_DATA_DONE;
                    if (left_next == '0)
                        phase_next = PH_HEADER;
                end
            end
            default:
            begin
                phase_next = PH_HALT;
            end
        endcase
    end

    assign q_data = c;

    // Advance state on each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            off_reg <= '0;
            bsum_reg <= '0;
            zero_reg <= 1'b1;
            sacc_reg <= '0;
            sst_reg <= PS_SKIP;
            cacc_reg <= '0;
            cst_reg <= PS_SKIP;
            type_reg <= '0;
            left_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            off_reg <= off_next;
            bsum_reg <= bsum_next;
            zero_reg <= zero_next;
            sacc_reg <= sacc_next;
            sst_reg <= sst_next;
            cacc_reg <= cacc_next;
            cst_reg <= cst_next;
            type_reg <= type_next;
            left_reg <= left_next;
        end
    end
endmodule
`default_nettype wire

[rtl/tsbp_fifo.sv]
// Two-entry queue between front and back.
// Depends on tsbp_pkg.
`default_nettype none
module tsbp_fifo
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic wr_valid,
    output logic wr_ready,
    input wire tsbp_pkg::cls_t wr_data,
    output logic rd_valid,
    input wire logic rd_ready,
    output tsbp_pkg::cls_t rd_data
);
    import tsbp_pkg::*;

    cls_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

[rtl/tsbp_back.sv]
// Back: payload marking and file end, drives the registered result.
// Depends on tsbp_pkg.
`default_nettype none
module tsbp_back
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic q_valid,
    output logic q_ready,
    input wire tsbp_pkg::cls_t q_data,
    output logic out_valid,
    input wire logic out_ready,
    output tsbp_pkg::res_t out_data
);
    import tsbp_pkg::*;

    logic [SIZE_W-1:0] left_reg;
    logic wflag_reg;
    logic ov_reg;
    res_t res_reg;
    res_t r;
    logic take;

    assign q_ready = !ov_reg || out_ready;
    assign take = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_data = res_reg;

    // Form the result
    always_comb
    begin
        r = '0;
        r.data_byte = q_data.data;
        r.status = q_data.status;
        r.entry_type = q_data.etype;
        r.file_size = q_data.size;
        if (q_data.in_data && left_reg != '0 && wflag_reg)
        begin
            r.payload_valid = 1'b1;
            r.file_end = left_reg == SIZE_W'(1);
        end
    end

    // Track the entry's remaining bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            wflag_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                ov_reg <= 1'b1;
                if (q_data.hdr_ok)
                begin
                    left_reg <= q_data.size;
                    wflag_reg <= !(q_data.etype >= 8'h31 && q_data.etype <= 8'h36);
                end
                else if (q_data.in_data && left_reg != '0)
                    left_reg <= left_reg - 1'b1;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= r;
    end
endmodule
`default_nettype wire

[rtl/tar_stream_block_parser_top.sv]
// Top level of the tar stream block parser.
// Depends on tsbp_pkg, tsbp_if, tsbp_front, tsbp_fifo, tsbp_back.
//
// One byte is taken per cycle while the sink keeps ready high, and one result
// leaves per byte. An accepted byte is held in the two-entry queue and then in
// the output register before it leaves. The front parses headers and tracks
// the block phase; the back marks payload bytes. The queue and the output
// register separate them, so the throughput is one byte per clock whenever
// the sink keeps ready high; when the sink stalls, the queue and the output
// register fill and the input stalls once they hold three bytes.
`default_nettype none
module tar_stream_block_parser_top
(
    input wire logic clk,
    input wire logic rst_n,
    tsbp_if.sink in_ch,
    tsbp_if.source out_ch
);
    import tsbp_pkg::*;

    logic f_valid, f_ready, b_valid, b_ready;
    cls_t f_data, b_data;

    tsbp_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_byte(in_ch.payload.stream_byte),
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    tsbp_fifo u_fifo
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    tsbp_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_data(out_ch.payload)
    );
endmodule
`default_nettype wire

[rtl/tsbp_checker.sv]
// Port-level checker for the tar stream block parser, bound to the top level.
// Depends on tsbp_pkg.
`default_nettype none
module tsbp_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire tsbp_pkg::res_t out_data
);
    import tsbp_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Status stays in range
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= 3'd5)
        else $error("bad status");

    // File end only on payload bytes
    a_fend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.file_end |-> out_data.payload_valid)
        else $error("file end without payload");

    // Halted results carry nothing
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_HALTED |->
        !out_data.payload_valid && out_data.file_size == '0)
        else $error("halted result carries data");
endmodule

bind tar_stream_block_parser_top tsbp_checker u_chk
(
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.payload)
);
`default_nettype wire
